[src/dlvs_pkg.sv]
// Package for the dual LFO vibrato stride block: widths, register indexes,
// sequencer states and the shared-multiplier operand bundle. No dependencies.
package dlvs_pkg;

	localparam int MaxBuffer = 4096;
	localparam int SineTableBits = 10;
	localparam int LenW = 13;
	localparam int OutW = 19;
	localparam logic [OutW-1:0] OutSat = 19'd262144;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_MAIN_RATE = 3'd0,
		REG_MOD_RATE = 3'd1,
		REG_RATE_DEPTH = 3'd2,
		REG_DEPTH_DEPTH = 3'd3,
		REG_WIDTH_SCALE = 3'd4,
		REG_WIDTH_SEMI = 3'd5
	} reg_idx_t;

	// sequencer states; each arithmetic state but ST_D2 issues one multiply
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MODPH,
		ST_S2_X2, ST_S2_T1, ST_S2_T2, ST_S2_Y,
		ST_M,
		ST_DL1, ST_DL2, ST_DL3,
		ST_D1, ST_D2,
		ST_S1_X2, ST_S1_T1, ST_S1_T2, ST_S1_Y,
		ST_V, ST_NUM, ST_E,
		ST_X1, ST_X2, ST_X3, ST_OUT,
		ST_DONE
	} state_t;

	// operand bundle to the shared multiplier
	typedef struct packed {
		logic signed [34:0] a;
		logic signed [34:0] b;
	} mul_req_t;

endpackage

[src/dlvs_if.sv]
// Valid/ready channel interfaces for the block: the stream channels for the
// input and result beats and the register write channel. Depends on nothing.
interface dlvs_stream_if #(parameter int W = 1);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dlvs_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

[src/dlvs_mul.sv]
// Shared signed multiplier, 35 x 35 as two 35 x 18 partial products taken in
// turn through one multiplier. Depends on dlvs_pkg.
module dlvs_mul (
	input logic clk,
	input logic arst_n,
	input logic start,
	input dlvs_pkg::mul_req_t req,
	output logic done,
	output logic signed [69:0] prod
);
	import dlvs_pkg::*;

	logic signed [34:0] a_q;
	logic [17:0] bh_q;
	logic signed [52:0] lo_q;
	logic busy_q;
	logic signed [34:0] pa;
	logic signed [17:0] pb;
	logic signed [52:0] pp;

	// on start: low 17 bits of b, unsigned; while busy: high part, signed
	assign pa = busy_q ? a_q : req.a;
	assign pb = busy_q ? $signed(bh_q) : $signed({1'b0, req.b[16:0]});
	assign pp = pa * pb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= busy_q;
			busy_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= req.a;
			bh_q <= req.b[34:17];
			lo_q <= pp;
		end
		if (busy_q) prod <= (70'(pp) <<< 17) + 70'(lo_q);
	end
endmodule

[src/dlvs_seq.sv]
// Sequencer: holds phases and state, steps the arithmetic through the shared
// multiplier. Depends on dlvs_pkg and dlvs_mul.
module dlvs_seq (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [dlvs_pkg::LenW-1:0] len,
	input logic [30:0] main_rate,
	input logic [30:0] mod_rate,
	input logic [15:0] rate_depth,
	input logic [15:0] depth_depth,
	input logic signed [16:0] wscale,
	input logic [15:0] wsemi,
	output logic busy,
	output logic res_valid,
	output logic [dlvs_pkg::OutW-1:0] res,
	input logic res_take
);
	import dlvs_pkg::*;

	state_t state_q, state_d;
	logic issued_q;
	logic [31:0] main_ph_q, mod_ph_q;
	logic [LenW-1:0] prev_q, next_len_q;
	logic signed [34:0] acc_q;   // general working register
	logic signed [34:0] x_q;     // sine argument / exp fraction
	logic signed [34:0] x2_q;
	logic signed [34:0] s2_q;
	logic sneg_q;
	logic signed [6:0] n_q;
	logic mstart, mdone;
	mul_req_t mreq;
	logic signed [69:0] prod;
	logic signed [69:0] pf15;
	logic [OutW-1:0] res_q;
	logic rv_q;

	dlvs_mul u_mul (.clk, .arst_n, .start(mstart), .req(mreq), .done(mdone), .prod);

	// floor shift by 15 is an arithmetic shift
	assign pf15 = prod >>> 15;

	function automatic logic [34:0] sin_x(input logic [31:0] ph);
		logic [SineTableBits-3:0] f;
		logic [15:0] x;
		begin
			f = ph[31-2 -: SineTableBits-2];
			x = {1'b0, f, {(17-SineTableBits){1'b0}}};
			if (ph[30]) x = 16'd32768 - x;
			sin_x = 35'(x);
		end
	endfunction

	// next state and multiplier request
	always_comb begin
		state_d = state_q;
		mstart = 1'b0;
		mreq.a = '0;
		mreq.b = '0;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_MODPH;
			ST_MODPH: begin mreq.a = 35'(mod_rate); mreq.b = 35'(prev_q); end
			ST_S2_X2, ST_S1_X2: begin mreq.a = x_q; mreq.b = x_q; end
			ST_S2_T1, ST_S1_T1: begin mreq.a = 35'sd2605; mreq.b = x2_q; end
			ST_S2_T2, ST_S1_T2: begin mreq.a = acc_q; mreq.b = x2_q; end
			ST_S2_Y, ST_S1_Y: begin mreq.a = acc_q; mreq.b = x_q; end
			ST_M: begin mreq.a = s2_q; mreq.b = 35'(rate_depth); end
			// m * previous length first, so the full product keeps every bit
			ST_DL1: begin mreq.a = acc_q; mreq.b = 35'(prev_q); end
			ST_DL2: begin mreq.a = 35'(main_rate); mreq.b = acc_q; end
			ST_DL3: begin mreq.a = s2_q; mreq.b = 35'(depth_depth); end
			ST_D1: begin mreq.a = acc_q; mreq.b = 35'(wscale); end
			ST_D2: begin mreq.a = 35'sd0; mreq.b = 35'sd0; end
			// depth parked in s2_q, main sine in x2_q
			ST_V: begin mreq.a = s2_q; mreq.b = x2_q; end
			ST_NUM: begin mreq.a = acc_q; mreq.b = 35'(wsemi); end
			// floor(num/24576) = floor(floor(num/2^13)/3); offset by 3*2^21 to keep
			// the dividend positive, then multiply by ceil(2^24/3)
			ST_E: begin
				mreq.a = (acc_q >>> 13) + 35'sd6291456;
				mreq.b = 35'sd5592406;
			end
			ST_X1: begin mreq.a = 35'(acc_q[15:0]); mreq.b = 35'sd5118; end
			ST_X2, ST_X3: begin mreq.a = acc_q; mreq.b = x_q; end
			ST_OUT: ;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (state_q != ST_IDLE && state_q != ST_DONE && state_q != ST_OUT && state_q != ST_D2)
			mstart = !issued_q;
		// output stage waits while the previous stride is still held
		if (state_q == ST_D2 || (state_q == ST_OUT && !rv_q))
			state_d = state_t'(state_q + 5'd1);
		else if (mdone) state_d = state_t'(state_q + 5'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issued_q <= 1'b0;
			main_ph_q <= '0;
			mod_ph_q <= '0;
			prev_q <= '0;
			rv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			issued_q <= mdone ? 1'b0 : (issued_q | mstart);
			if (state_q == ST_OUT && !rv_q) rv_q <= 1'b1;
			else if (res_take) rv_q <= 1'b0;
			if (state_q == ST_OUT && !rv_q) prev_q <= next_len_q;
			if (mdone && state_q == ST_MODPH) mod_ph_q <= mod_ph_q + prod[31:0];
			if (mdone && state_q == ST_DL2) main_ph_q <= main_ph_q + pf15[31:0];
		end
	end

	// datapath updates after each product
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start)
			next_len_q <= (len > LenW'(MaxBuffer)) ? LenW'(MaxBuffer) : len;
		if (mdone) begin
			case (state_q)
				ST_MODPH: begin
					x_q <= sin_x(mod_ph_q + prod[31:0]);
					sneg_q <= (mod_ph_q + prod[31:0]) >= 32'h8000_0000;
				end
				ST_S2_X2, ST_S1_X2: x2_q <= pf15[34:0];
				ST_S2_T1, ST_S1_T1: acc_q <= 35'sd21167 - pf15[34:0];
				ST_S2_T2, ST_S1_T2: acc_q <= 35'sd51472 - pf15[34:0];
				ST_S2_Y: s2_q <= sneg_q ? -((pf15 > 70'sd32767) ? 35'sd32767 : pf15[34:0])
					: ((pf15 > 70'sd32767) ? 35'sd32767 : pf15[34:0]);
				ST_M: acc_q <= 35'sd32768 + pf15[34:0];
				ST_DL1: acc_q <= prod[34:0];
				ST_DL2: begin
					x_q <= sin_x(main_ph_q + pf15[31:0]);
					sneg_q <= (main_ph_q + pf15[31:0]) >= 32'h8000_0000;
				end
				ST_DL3: acc_q <= 35'sd32768 - pf15[34:0];
				ST_D1: acc_q <= pf15[34:0];
				ST_S1_Y: x2_q <= sneg_q ? -((pf15 > 70'sd32767) ? 35'sd32767 : pf15[34:0])
					: ((pf15 > 70'sd32767) ? 35'sd32767 : pf15[34:0]);
				ST_V: acc_q <= pf15[34:0];
				ST_NUM: acc_q <= prod[34:0];
				ST_E: begin
					// remove the 2^21 quotient offset
					acc_q <= 35'(prod >>> 24) - 35'sd2097152;
				end
				ST_X1: acc_q <= 35'sd14818 + 35'(prod >>> 16);
				ST_X2: acc_q <= 35'sd45600 + 35'(prod >>> 16);
				ST_X3: acc_q <= 35'sd65536 + 35'(prod >>> 16);
				default: ;
			endcase
		end
		// keep the depth while the main sine runs
		if (state_q == ST_D2) s2_q <= acc_q;
		// set up exp2 fraction after e is known
		if (state_q == ST_X1 && !issued_q) begin
			x_q <= 35'(acc_q[15:0]);
			n_q <= ($signed(acc_q[34:16]) > 19'sd2) ? 7'sd2
				: ($signed(acc_q[34:16]) < -19'sd32) ? -7'sd32 : 7'(acc_q[34:16]);
		end
		if (state_q == ST_OUT && !rv_q) begin
			if (n_q >= 7'sd2) res_q <= OutSat;
			else if (n_q >= 7'sd0)
				res_q <= (36'(acc_q) << n_q) > 36'(OutSat) ? OutSat
					: OutW'(acc_q << n_q);
			else if (n_q <= -7'sd32) res_q <= '0;
			else res_q <= OutW'(acc_q >>> (-n_q));
		end
	end

	assign busy = state_q != ST_IDLE;
	assign res_valid = rv_q;
	assign res = res_q;

	// assertions
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy && state_q != ST_DONE |-> !(state_q == ST_IDLE)) else $error("seq");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rv_q && !res_take |=> rv_q && $stable(res_q)) else $error("res drop");
	a_mul_one: assert property (@(posedge clk) disable iff (!arst_n)
		mstart |=> !mstart) else $error("double issue");
endmodule

[src/dual_lfo_vibrato_stride.sv]
// Dual LFO vibrato stride multiplier. One buffer length in, one Q3.16 stride
// out. Each item runs 20 multiplies in turn through one shared multiplier
// (issue with the low partial product, then the high partial product), plus
// states to park the depth, to form the output and to return to idle. The
// input is not ready until the item is done. The output register frees the
// sequencer; only when the previous stride is still waiting does the next
// item stall before its result is written. The user must write registers
// through the config channel only while idle; the block does not enforce it.
module dual_lfo_vibrato_stride (
	input logic clk,
	input logic arst_n,
	dlvs_stream_if.sink in_ch,
	dlvs_stream_if.source out_ch,
	dlvs_cfg_if.sink cfg
);
	import dlvs_pkg::*;

	logic [30:0] main_rate_q, mod_rate_q;
	logic [15:0] rate_depth_q, depth_depth_q, wsemi_q;
	logic signed [16:0] wscale_q;
	logic busy;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = !busy;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_rate_q <= 31'd402653;
			mod_rate_q <= 31'd16269;
			rate_depth_q <= 16'd3277;
			depth_depth_q <= 16'd3277;
			wscale_q <= 17'sd32768;
			wsemi_q <= 16'd819;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MAIN_RATE: main_rate_q <= cfg.wdata[30:0];
				REG_MOD_RATE: mod_rate_q <= cfg.wdata[30:0];
				REG_RATE_DEPTH: rate_depth_q <= cfg.wdata[15:0];
				REG_DEPTH_DEPTH: depth_depth_q <= cfg.wdata[15:0];
				REG_WIDTH_SCALE: wscale_q <= cfg.wdata[16:0];
				REG_WIDTH_SEMI: wsemi_q <= cfg.wdata[15:0];
				default: ;
			endcase
		end
	end

	dlvs_seq u_seq (
		.clk, .arst_n,
		.start(in_ch.valid && in_ch.ready),
		.len(in_ch.data[LenW-1:0]),
		.main_rate(main_rate_q), .mod_rate(mod_rate_q),
		.rate_depth(rate_depth_q), .depth_depth(depth_depth_q),
		.wscale(wscale_q), .wsemi(wsemi_q),
		.busy, .res_valid(out_ch.valid), .res(out_ch.data[OutW-1:0]),
		.res_take(out_ch.valid && out_ch.ready)
	);
endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for the dual LFO vibrato stride block: predicts each stride from
// the buffer lengths and registers, and checks every output beat in order.
// Depends on dlvs_pkg, the channel interfaces and the top module in src.
module tb_top;
	import dlvs_pkg::*;

	logic clk;
	logic arst_n;

	dlvs_stream_if #(.W(LenW)) in_ch ();
	dlvs_stream_if #(.W(OutW)) out_ch ();
	dlvs_cfg_if cfg ();

	dual_lfo_vibrato_stride i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	// predictor state
	logic [30:0] main_rate;
	logic [30:0] mod_rate;
	logic [15:0] rate_depth;
	logic [15:0] depth_depth;
	logic [16:0] width_scale;
	logic [15:0] width_semi;
	logic [31:0] main_phase;
	logic [31:0] mod_phase;
	logic [12:0] prev_len;

	logic [OutW-1:0] stride_q[$];
	int mismatches;
	int send_idle_pct;
	int recv_idle_pct;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#50ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic longint fl_shift(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -(((-v) + ((longint'(1) << s) - 1)) >>> s);
	endfunction

	// polynomial sine of the phase, Q1.15
	function automatic longint sine_of(logic [31:0] ph);
		logic [SineTableBits-1:0] idx;
		logic [1:0] quad;
		longint x, x2, t, y;
		idx = ph[31 -: SineTableBits];
		quad = idx[SineTableBits-1 -: 2];
		x = longint'(idx[SineTableBits-3:0]) << (17 - SineTableBits);
		if (quad[0])
			x = 32768 - x;
		x2 = (x * x) >> 15;
		t = (2605 * x2) >> 15;
		t = 21167 - t;
		t = (t * x2) >> 15;
		t = 51472 - t;
		y = (t * x) >> 15;
		if (y > 32767)
			y = 32767;
		return quad[1] ? -y : y;
	endfunction

	// 2^e for e in Q.16, saturated at 4.0
	function automatic logic [OutW-1:0] pow2_of(longint e);
		longint n, f, t, p, r;
		n = fl_shift(e, 16);
		f = e - n * 65536;
		if (n >= 2)
			return OutSat;
		t = (f * 5118) >> 16;
		t = ((14818 + t) * f) >> 16;
		t = ((45600 + t) * f) >> 16;
		p = 65536 + t;
		if (n >= 0)
			r = p << n;
		else if (-n >= 32)
			r = 0;
		else
			r = p >> (-n);
		if (r > 262144)
			r = 262144;
		return r[OutW-1:0];
	endfunction

	function automatic logic [OutW-1:0] next_stride(logic [12:0] len_in);
		longint ws, s2, m, delta, d, v, num, e;
		logic [12:0] len;
		ws = longint'($signed(width_scale));
		len = (len_in > MaxBuffer) ? 13'(MaxBuffer) : len_in;
		mod_phase = mod_phase + 32'(longint'(mod_rate) * longint'(prev_len));
		s2 = sine_of(mod_phase);
		m = 32768 + fl_shift(s2 * longint'(rate_depth), 15);
		delta = fl_shift(longint'(main_rate) * m * longint'(prev_len), 15);
		main_phase = main_phase + 32'(delta);
		d = 32768 - fl_shift(s2 * longint'(depth_depth), 15);
		d = fl_shift(d * ws, 15);
		v = fl_shift(sine_of(main_phase) * d, 15);
		num = v * longint'(width_semi);
		e = num / 24576;
		if (num % 24576 != 0 && num < 0)
			e -= 1;
		prev_len = len;
		return pow2_of(e);
	endfunction

	task automatic predictor_reset();
		main_rate = 31'd402653;
		mod_rate = 31'd16269;
		rate_depth = 16'd3277;
		depth_depth = 16'd3277;
		width_scale = 17'd32768;
		width_semi = 16'd819;
		main_phase = '0;
		mod_phase = '0;
		prev_len = '0;
	endtask

	// one buffer length beat, with random sender gaps
	task automatic send_len(logic [12:0] len);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
			@(posedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data <= len;
		do
			@(posedge clk);
		while (!in_ch.ready);
		stride_q.push_back(next_stride(len));
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// register write; only called with the block idle
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.wdata <= val;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_MAIN_RATE: main_rate = val[30:0];
			REG_MOD_RATE: mod_rate = val[30:0];
			REG_RATE_DEPTH: rate_depth = val[15:0];
			REG_DEPTH_DEPTH: depth_depth = val[15:0];
			REG_WIDTH_SCALE: width_scale = val[16:0];
			REG_WIDTH_SEMI: width_semi = val[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		while (stride_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_all(logic [31:0] mr, logic [31:0] dr, logic [31:0] rd,
		logic [31:0] dd, logic [31:0] ws, logic [31:0] wsemi);
		drain();
		write_reg(REG_MAIN_RATE, mr);
		write_reg(REG_MOD_RATE, dr);
		write_reg(REG_RATE_DEPTH, rd);
		write_reg(REG_DEPTH_DEPTH, dd);
		write_reg(REG_WIDTH_SCALE, ws);
		write_reg(REG_WIDTH_SEMI, wsemi);
	endtask

	function automatic logic [12:0] rand_len();
		int k;
		k = $urandom_range(99);
		if (k < 5)
			return 13'($urandom_range(8191));
		if (k < 10)
			return 13'($urandom_range(1) ? 0 : 4096);
		return 13'($urandom_range(4096, 1));
	endfunction

	// reset defaults, extremes of the buffer length, wrap and long buffers
	task automatic test_directed();
		send_len(13'd1);
		send_len(13'd4096);
		send_len(13'd4097);
		send_len(13'd8191);
		send_len(13'd0);
		send_len(13'd1);
		send_len(13'h0AAA);
		send_len(13'h1555);
		send_len(13'd4096);
		send_len(13'd4095);
	endtask

	// largest rates, depths beyond one, full width, saturating exponent
	task automatic test_extremes();
		write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF, 32'hFFFF, 32'h1_0000, 32'hFFFF);
		for (int i = 0; i < 6; i++)
			send_len(i[0] ? 13'd4096 : 13'd1);
		write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'h1_FFFF, 32'd0);
		send_len(13'd100);
		send_len(13'd4096);
		write_all(32'h4000_0000, 32'h0123_4567, 32'd32768, 32'd32768, 32'd32768,
			32'd49152);
		for (int i = 0; i < 6; i++)
			send_len(13'd4096 - 13'(i * 511));
		write_all(32'hFFFF_FFFF, 32'h8000_0001, 32'h8000, 32'h7FFF, 32'h0_8000, 32'h8000);
		send_len(13'd2048);
		send_len(13'd3);
	endtask

	// random lengths under random register settings
	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 120 == 0)
				write_all($urandom, $urandom, $urandom_range(1) ? $urandom : 32'($urandom_range(32768)),
					$urandom_range(1) ? $urandom : 32'($urandom_range(32768)),
					$urandom_range(1) ? $urandom : 32'($urandom_range(32768)),
					$urandom_range(1) ? $urandom : 32'($urandom_range(49152)));
			send_len(rand_len());
		end
	endtask

	// output checking and receiver stalls
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (stride_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("stride beat with nothing expected: %0d", out_ch.data);
			end else begin
				logic [OutW-1:0] want;
				want = stride_q.pop_front();
				if (out_ch.data !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("stride mismatch: expected %0d, got %0d", want, out_ch.data);
				end
			end
		end
		out_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
	end

	initial begin
		mismatches = 0;
		send_idle_pct = 21;
		recv_idle_pct = 73;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_MAIN_RATE;
		cfg.wdata = '0;
		predictor_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_extremes();
		test_random(470);
		drain();
		send_idle_pct = 73;
		recv_idle_pct = 21;
		test_random(470);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(470);
		drain();

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

[filelist.f]
src/dlvs_pkg.sv
src/dlvs_if.sv
src/dlvs_mul.sv
src/dlvs_seq.sv
src/dual_lfo_vibrato_stride.sv
sim/tb_top.sv
